[design/ppp_pkg.sv]
// Shared types and constants for the pinhole pose projection block.
package ppp_pkg;

    localparam int COORD_W = 32;
    localparam int POSE_SLOTS = 12;
    localparam int ROT_FRAC = 30;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_FWD  = 2'd1,
        CMD_BACK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_FOCAL_X  = 2'd0,
        REG_FOCAL_Y  = 2'd1,
        REG_CENTER_X = 2'd2,
        REG_CENTER_Y = 2'd3
    } reg_idx_t;

    localparam logic [31:0] FOCAL_X_RST  = 32'd32768000;
    localparam logic [31:0] FOCAL_Y_RST  = 32'd32768000;
    localparam logic [31:0] CENTER_X_RST = 32'd20971520;
    localparam logic [31:0] CENTER_Y_RST = 32'd15728640;
    localparam logic [31:0] ROT_ONE      = 32'h4000_0000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
        logic [3:0]         pose_slot;
        logic signed [31:0] pose_word;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic               bad_depth;
        logic               saturated;
    } out_item_t;

endpackage

[design/pinhole_pose_projection.sv]
// Pinhole camera projection with rigid pose: pipelined forward and back projection.
//
// Takes one point transaction per cycle while the output is not stalled; most of
// the pipe is the 40-stage restoring divider (one quotient bit per stage,
// one divider lane each for x and y). A stalled output freezes the whole pipe.
// A pose load transaction is held off until the pipe is empty, then writes its
// slot in the accept cycle and produces no result. The user must write configuration
// registers over the APB port only while the block is idle; it is not enforced.
module pinhole_pose_projection (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ppp_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ppp_pkg::out_item_t  out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ppp_pkg::*;

    localparam int DIV_BITS = 40;
    localparam int ST_DIV0  = 6;
    localparam int ST_RND   = ST_DIV0 + DIV_BITS;
    localparam int NSTG     = ST_RND + 5;

    typedef struct packed {
        logic              fwd;
        logic [2:0][31:0]  pt;
        logic [2:0][31:0]  cam;
        logic [1:0][31:0]  pix;
        logic [2:0][31:0]  wld;
        logic [2:0][31:0]  diff;
        logic [8:0][63:0]  prod;
        logic [1:0][33:0]  dd;
        logic [1:0][32:0]  opa;
        logic [1:0][31:0]  opb;
        logic [1:0][31:0]  den;
        logic [1:0]        neg;
        logic [1:0]        dz;
        logic [1:0][63:0]  num;
        logic [1:0]        big;
        logic [1:0][32:0]  rem;
        logic [1:0][39:0]  quo;
        logic [1:0][40:0]  qm;
        logic              bad;
        logic              satf;
    } item_t;

    localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;
    localparam logic signed [66:0] ROT_RND = 67'sd536870912;
    localparam logic [40:0]        QUOT_LIM = 41'h100_0000_0000;

    logic [31:0]  focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [31:0]  pose_reg [POSE_SLOTS];
    item_t        stg_reg  [NSTG];
    item_t        stg_next [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic         adv, busy, in_acc, item_in, cfg_wr;

    // {clipped, value}
    function automatic logic [32:0] sat_q(input logic signed [47:0] v);
        logic [32:0] r;
        if (v > SAT_MAX)
            r = {1'b1, SAT_MAX[31:0]};
        else if (v < SAT_MIN)
            r = {1'b1, SAT_MIN[31:0]};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    function automatic logic [33:0] absv(input logic [33:0] x);
        logic [33:0] r;
        r = x[33] ? (34'd0 - x) : x;
        return r;
    endfunction

    assign adv     = !(vld_reg[NSTG-1] && out_stall);
    assign busy    = |vld_reg;
    assign in_stall = !adv || (in_data.cmd == CMD_LOAD && busy);
    assign in_acc  = in_valid && !in_stall;
    assign item_in = in_acc && (in_data.cmd == CMD_FWD || in_data.cmd == CMD_BACK);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_FOCAL_X:  prdata = focal_x_reg;
            REG_FOCAL_Y:  prdata = focal_y_reg;
            REG_CENTER_X: prdata = center_x_reg;
            REG_CENTER_Y: prdata = center_y_reg;
            default:      prdata = focal_x_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FOCAL_X_RST;
            focal_y_reg  <= FOCAL_Y_RST;
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            for (int i = 0; i < POSE_SLOTS; i++)
                pose_reg[i] <= (i == 0 || i == 4 || i == 8) ? ROT_ONE : 32'd0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_FOCAL_X:  focal_x_reg  <= pwdata;
                    REG_FOCAL_Y:  focal_y_reg  <= pwdata;
                    REG_CENTER_X: center_x_reg <= pwdata;
                    REG_CENTER_Y: center_y_reg <= pwdata;
                    default:      focal_x_reg  <= focal_x_reg;
                endcase
            end
            if (in_acc && in_data.cmd == CMD_LOAD && in_data.pose_slot < 4'(POSE_SLOTS))
                pose_reg[in_data.pose_slot] <= in_data.pose_word;
        end
    end

    always_comb
    begin
        logic signed [66:0] rsum;
        logic [32:0]        sres;
        logic [32:0]        tdiv;
        logic               ge;
        logic signed [41:0] sq;
        logic [33:0]        mtmp;

        rsum = '0;
        sres = '0;
        tdiv = '0;
        ge   = 1'b0;
        sq   = '0;
        mtmp = '0;

        stg_next[0]     = '0;
        stg_next[0].fwd = (in_data.cmd == CMD_FWD);
        stg_next[0].pt  = {in_data.coord_c, in_data.coord_b, in_data.coord_a};
        for (int k = 1; k < NSTG; k++)
            stg_next[k] = stg_reg[k-1];

        // forward rotation products
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                stg_next[1].prod[3*i+j] =
                    64'($signed(pose_reg[3*i+j]) * $signed(stg_reg[0].pt[j]));

        // camera point (forward) or pixel offsets (back)
        if (stg_reg[1].fwd)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rsum = 67'($signed(stg_reg[1].prod[3*i]))
                     + 67'($signed(stg_reg[1].prod[3*i+1]))
                     + 67'($signed(stg_reg[1].prod[3*i+2]))
                     + (67'($signed(pose_reg[9+i])) <<< ROT_FRAC)
                     + ROT_RND;
                sres = sat_q(48'(rsum >>> ROT_FRAC));
                stg_next[2].cam[i] = sres[31:0];
                stg_next[2].satf   = stg_next[2].satf | sres[32];
            end
        end
        else
        begin
            stg_next[2].cam[2] = stg_reg[1].pt[2];
            stg_next[2].dd[0] = {{2{stg_reg[1].pt[0][31]}}, stg_reg[1].pt[0]}
                              - {2'b00, center_x_reg};
            stg_next[2].dd[1] = {{2{stg_reg[1].pt[1][31]}}, stg_reg[1].pt[1]}
                              - {2'b00, center_y_reg};
        end

        // divider operands
        if (stg_reg[2].fwd)
        begin
            for (int l = 0; l < 2; l++)
            begin
                mtmp = absv({{2{stg_reg[2].cam[l][31]}}, stg_reg[2].cam[l]});
                stg_next[3].opa[l] = mtmp[32:0];
                stg_next[3].neg[l] = stg_reg[2].cam[l][31] ^ stg_reg[2].cam[2][31];
                mtmp = absv({{2{stg_reg[2].cam[2][31]}}, stg_reg[2].cam[2]});
                stg_next[3].den[l] = mtmp[31:0];
                stg_next[3].dz[l]  = (stg_reg[2].cam[2] == 32'd0);
            end
            stg_next[3].opb[0] = focal_x_reg;
            stg_next[3].opb[1] = focal_y_reg;
        end
        else
        begin
            mtmp = absv({{2{stg_reg[2].pt[2][31]}}, stg_reg[2].pt[2]});
            for (int l = 0; l < 2; l++)
            begin
                stg_next[3].opb[l] = mtmp[31:0];
                stg_next[3].neg[l] = stg_reg[2].dd[l][33] ^ stg_reg[2].pt[2][31];
            end
            mtmp = absv(stg_reg[2].dd[0]);
            stg_next[3].opa[0] = mtmp[32:0];
            mtmp = absv(stg_reg[2].dd[1]);
            stg_next[3].opa[1] = mtmp[32:0];
            stg_next[3].den[0] = focal_x_reg;
            stg_next[3].den[1] = focal_y_reg;
            stg_next[3].dz[0]  = (focal_x_reg == 32'd0);
            stg_next[3].dz[1]  = (focal_y_reg == 32'd0);
        end

        // dividends
        for (int l = 0; l < 2; l++)
            stg_next[4].num[l] = 64'(stg_reg[3].opa[l] * stg_reg[3].opb[l]);

        // quotients of 2^40 or more clip; otherwise the top bits seed the remainder
        for (int l = 0; l < 2; l++)
        begin
            stg_next[5].big[l] = {8'd0, stg_reg[4].num[l][63:40]} >= stg_reg[4].den[l];
            stg_next[5].rem[l] = {9'd0, stg_reg[4].num[l][63:40]};
            stg_next[5].quo[l] = '0;
        end

        // restoring division, one quotient bit per stage
        for (int k = 0; k < DIV_BITS; k++)
            for (int l = 0; l < 2; l++)
            begin
                tdiv = {stg_reg[ST_DIV0-1+k].rem[l][31:0],
                        stg_reg[ST_DIV0-1+k].num[l][DIV_BITS-1-k]};
                ge   = tdiv >= {1'b0, stg_reg[ST_DIV0-1+k].den[l]};
                stg_next[ST_DIV0+k].rem[l] =
                    ge ? (tdiv - {1'b0, stg_reg[ST_DIV0-1+k].den[l]}) : tdiv;
                stg_next[ST_DIV0+k].quo[l] = {stg_reg[ST_DIV0-1+k].quo[l][DIV_BITS-2:0], ge};
            end

        // round half away from zero on the magnitude, then clip
        for (int l = 0; l < 2; l++)
        begin
            ge = {stg_reg[ST_RND-1].rem[l], 1'b0} >= {2'b00, stg_reg[ST_RND-1].den[l]};
            stg_next[ST_RND].qm[l] = stg_reg[ST_RND-1].big[l] ? QUOT_LIM
                                   : ({1'b0, stg_reg[ST_RND-1].quo[l]} + 41'(ge));
        end

        // apply sign; pixel (forward) or camera x/y (back)
        for (int l = 0; l < 2; l++)
        begin
            sq = stg_reg[ST_RND].neg[l] ? (42'sd0 - $signed({1'b0, stg_reg[ST_RND].qm[l]}))
                                       : $signed({1'b0, stg_reg[ST_RND].qm[l]});
            if (stg_reg[ST_RND].fwd)
            begin
                if (stg_reg[ST_RND].dz[l])
                begin
                    stg_next[ST_RND+1].pix[l] = '0;
                    stg_next[ST_RND+1].bad    = 1'b1;
                end
                else
                begin
                    sres = sat_q(48'(sq) + $signed({16'd0,
                                 (l == 0) ? center_x_reg : center_y_reg}));
                    stg_next[ST_RND+1].pix[l] = sres[31:0];
                    stg_next[ST_RND+1].satf   = stg_next[ST_RND+1].satf | sres[32];
                end
            end
            else
            begin
                stg_next[ST_RND+1].pix[l] = stg_reg[ST_RND].pt[l];
                if (stg_reg[ST_RND].dz[l])
                begin
                    stg_next[ST_RND+1].cam[l] = '0;
                    stg_next[ST_RND+1].bad    = 1'b1;
                end
                else
                begin
                    sres = sat_q(48'(sq));
                    stg_next[ST_RND+1].cam[l] = sres[31:0];
                    stg_next[ST_RND+1].satf   = stg_next[ST_RND+1].satf | sres[32];
                end
            end
        end

        // back: c - t, clipped
        if (!stg_reg[ST_RND+1].fwd)
            for (int i = 0; i < 3; i++)
            begin
                sres = sat_q(48'($signed(stg_reg[ST_RND+1].cam[i]))
                           - 48'($signed(pose_reg[9+i])));
                stg_next[ST_RND+2].diff[i] = sres[31:0];
                stg_next[ST_RND+2].satf    = stg_next[ST_RND+2].satf | sres[32];
            end

        // back: transposed rotation products
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                stg_next[ST_RND+3].prod[3*i+j] =
                    64'($signed(pose_reg[3*j+i]) * $signed(stg_reg[ST_RND+2].diff[j]));

        // world point
        if (stg_reg[ST_RND+3].fwd)
            stg_next[ST_RND+4].wld = stg_reg[ST_RND+3].pt;
        else
            for (int i = 0; i < 3; i++)
            begin
                rsum = 67'($signed(stg_reg[ST_RND+3].prod[3*i]))
                     + 67'($signed(stg_reg[ST_RND+3].prod[3*i+1]))
                     + 67'($signed(stg_reg[ST_RND+3].prod[3*i+2]))
                     + ROT_RND;
                sres = sat_q(48'(rsum >>> ROT_FRAC));
                stg_next[ST_RND+4].wld[i] = sres[31:0];
                stg_next[ST_RND+4].satf   = stg_next[ST_RND+4].satf | sres[32];
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], item_in};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int k = 0; k < NSTG; k++)
                stg_reg[k] <= stg_next[k];
    end

    assign out_valid          = vld_reg[NSTG-1];
    assign out_data.cam_x     = stg_reg[NSTG-1].cam[0];
    assign out_data.cam_y     = stg_reg[NSTG-1].cam[1];
    assign out_data.cam_z     = stg_reg[NSTG-1].cam[2];
    assign out_data.pixel_u   = stg_reg[NSTG-1].pix[0];
    assign out_data.pixel_v   = stg_reg[NSTG-1].pix[1];
    assign out_data.world_x   = stg_reg[NSTG-1].wld[0];
    assign out_data.world_y   = stg_reg[NSTG-1].wld[1];
    assign out_data.world_z   = stg_reg[NSTG-1].wld[2];
    assign out_data.bad_depth = stg_reg[NSTG-1].bad;
    assign out_data.saturated = stg_reg[NSTG-1].satf;

endmodule

[verif/pinhole_pose_projection_checker.sv]
// Scoreboard for the pinhole pose projection block: predicts each transaction and checks results.
module pinhole_pose_projection_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  ppp_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ppp_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 pending,
    output int                 errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import ppp_pkg::*;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam longint QUOT_CAP = 64'sd1 << 40;

    logic [31:0] fx, fy, cx, cy;
    longint      pose[POSE_SLOTS];
    out_item_t   expected_q[$];

    assign pending = expected_q.size();

    function automatic longint clip(longint v, inout bit flag);
        if (v > SAT_HI)
        begin
            flag = 1;
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            flag = 1;
            return SAT_LO;
        end
        return v;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // nearest, ties away from zero, magnitude capped at 2^40
    function automatic longint quot(bit neg, longint unsigned num, longint unsigned den);
        longint unsigned q, r;
        longint s;
        q = num / den;
        r = num % den;
        if (r >= den - r)
            q++;
        s = (q > QUOT_CAP) ? QUOT_CAP : longint'(q);
        return neg ? -s : s;
    endfunction

    // Q2.30 row times Q16.16 vector plus offset, exact then rounded half up
    function automatic longint rot_row(longint r0, longint r1, longint r2,
                                       longint c0, longint c1, longint c2, longint t);
        longint p[3];
        longint q, qs, rs;
        p[0] = r0 * c0;
        p[1] = r1 * c1;
        p[2] = r2 * c2;
        qs = 0;
        rs = 0;
        for (int i = 0; i < 3; i++)
        begin
            q = p[i] >>> 2;
            qs += q;
            rs += p[i] - q * 4;
        end
        qs += t * (64'sd1 << (ROT_FRAC - 2));
        qs += 64'sd1 << (ROT_FRAC - 3);
        qs += rs / 4;
        return qs >>> (ROT_FRAC - 2);
    endfunction

    function automatic out_item_t project(in_item_t it);
        out_item_t o;
        longint a, b, c, du, dv, pu, pv;
        longint cam[3], wld[3], diff[3];
        longint unsigned dz, dm;
        bit bad, sf;
        a = it.coord_a;
        b = it.coord_b;
        c = it.coord_c;
        bad = 0;
        sf = 0;
        if (cmd_t'(it.cmd) == CMD_FWD)
        begin
            wld[0] = a;
            wld[1] = b;
            wld[2] = c;
            for (int i = 0; i < 3; i++)
                cam[i] = clip(rot_row(pose[3*i], pose[3*i+1], pose[3*i+2],
                                      a, b, c, pose[9+i]), sf);
            if (cam[2] == 0)
            begin
                bad = 1;
                pu = 0;
                pv = 0;
            end
            else
            begin
                dz = abs64(cam[2]);
                pu = quot((cam[0] < 0) != (cam[2] < 0), abs64(cam[0]) * fx, dz)
                     + longint'({32'b0, cx});
                pv = quot((cam[1] < 0) != (cam[2] < 0), abs64(cam[1]) * fy, dz)
                     + longint'({32'b0, cy});
                pu = clip(pu, sf);
                pv = clip(pv, sf);
            end
        end
        else
        begin
            du = a - longint'({32'b0, cx});
            dv = b - longint'({32'b0, cy});
            dm = abs64(c);
            pu = a;
            pv = b;
            if (fx == 0)
            begin
                bad = 1;
                cam[0] = 0;
            end
            else
                cam[0] = clip(quot((du < 0) != (c < 0), abs64(du) * dm, fx), sf);
            if (fy == 0)
            begin
                bad = 1;
                cam[1] = 0;
            end
            else
                cam[1] = clip(quot((dv < 0) != (c < 0), abs64(dv) * dm, fy), sf);
            cam[2] = clip(c, sf);
            for (int i = 0; i < 3; i++)
                diff[i] = clip(cam[i] - pose[9+i], sf);
            // transpose: column i of R
            for (int i = 0; i < 3; i++)
                wld[i] = clip(rot_row(pose[i], pose[3+i], pose[6+i],
                                      diff[0], diff[1], diff[2], 0), sf);
        end
        o.cam_x = cam[0][31:0];
        o.cam_y = cam[1][31:0];
        o.cam_z = cam[2][31:0];
        o.pixel_u = pu[31:0];
        o.pixel_v = pv[31:0];
        o.world_x = wld[0][31:0];
        o.world_y = wld[1][31:0];
        o.world_z = wld[2][31:0];
        o.bad_depth = bad;
        o.saturated = sf;
        return o;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            fx <= FOCAL_X_RST;
            fy <= FOCAL_Y_RST;
            cx <= CENTER_X_RST;
            cy <= CENTER_Y_RST;
            for (int i = 0; i < POSE_SLOTS; i++)
                pose[i] = 0;
            pose[0] = ROT_ONE;
            pose[4] = ROT_ONE;
            pose[8] = ROT_ONE;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                case (reg_idx_t'(paddr[3:2]))
                    REG_FOCAL_X:  fx <= pwdata;
                    REG_FOCAL_Y:  fy <= pwdata;
                    REG_CENTER_X: cx <= pwdata;
                    REG_CENTER_Y: cy <= pwdata;
                    default: ;
                endcase
            if (in_valid && !in_stall)
                case (cmd_t'(in_data.cmd))
                    CMD_LOAD:
                        if (in_data.pose_slot < POSE_SLOTS)
                            pose[in_data.pose_slot] = longint'(in_data.pose_word);
                    CMD_FWD, CMD_BACK:
                        expected_q.push_back(project(in_data));
                    default: ;
                endcase
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with no expectation waiting");
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("cam_x", e.cam_x, out_data.cam_x);
                    check_field("cam_y", e.cam_y, out_data.cam_y);
                    check_field("cam_z", e.cam_z, out_data.cam_z);
                    check_field("pixel_u", e.pixel_u, out_data.pixel_u);
                    check_field("pixel_v", e.pixel_v, out_data.pixel_v);
                    check_field("world_x", e.world_x, out_data.world_x);
                    check_field("world_y", e.world_y, out_data.world_y);
                    check_field("world_z", e.world_z, out_data.world_z);
                    check_field("bad_depth", e.bad_depth, out_data.bad_depth);
                    check_field("saturated", e.saturated, out_data.saturated);
                end
            end
        end
    end

endmodule

[verif/pinhole_pose_projection_test.sv]
// Stimulus, register setup and verdict for the pinhole pose projection block.
module pinhole_pose_projection_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ppp_pkg::*;

    localparam int PIPE_DRAIN = 60;
    localparam int PHASE_ITEMS = 150;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    out_item_t   out_data;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          pending;
    int          errors;
    int          sent_count = 0;
    int          burst_left = 0;

    pinhole_pose_projection DUT (.*);

    pinhole_pose_projection_checker scoreboard (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    initial
    begin
        #5_000_000;
        $display("pinhole_pose_projection_test: FAIL");
        $finish;
    end

    // receiver: shifting stall pattern, plus one long hold-off to back up the pipe
    initial
    begin
        int mode, hold_left;
        bit held;
        mode = 0;
        hold_left = 0;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (!held && sent_count >= 300)
            begin
                held = 1;
                hold_left = 400;
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1;
            end
            else
                case (mode)
                    0: out_stall <= 0;
                    1: out_stall <= $urandom_range(0, 1);
                    2: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    task automatic send(in_item_t it);
        bit st;
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1;
        in_data <= it;
        forever
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
            if (!st)
                break;
        end
        burst_left--;
        sent_count++;
    endtask

    task automatic drain();
        in_valid <= 0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // leaves psel and penable high; the caller closes the access
    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
    endtask

    task automatic set_camera(logic [31:0] f_x, logic [31:0] f_y,
                              logic [31:0] c_x, logic [31:0] c_y);
        drain();
        reg_write(REG_FOCAL_X, f_x);
        reg_write(REG_FOCAL_Y, f_y);
        reg_write(REG_CENTER_X, c_x);
        reg_write(REG_CENTER_Y, c_y);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    function automatic in_item_t point(cmd_t op, logic [31:0] a, logic [31:0] b,
                                       logic [31:0] c);
        in_item_t it;
        it.cmd = op;
        it.coord_a = a;
        it.coord_b = b;
        it.coord_c = c;
        it.pose_slot = 4'($urandom);
        it.pose_word = $urandom;
        return it;
    endfunction

    function automatic in_item_t pose_load(logic [3:0] slot, logic [31:0] word);
        in_item_t it;
        it = point(CMD_LOAD, $urandom, $urandom, $urandom);
        it.pose_slot = slot;
        it.pose_word = word;
        return it;
    endfunction

    function automatic logic [31:0] coord_val(bit depth);
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return $urandom;
        if (k == 1)
            return 0;
        if (depth)
            return $urandom_range(ONE / 4, ONE * 40);
        return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    endfunction

    // signed permutation rotation with a small translation, twelve loads
    task automatic load_rigid_pose();
        int perm[3];
        int j, t;
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send(pose_load(4'(3*r + c), (perm[r] != c) ? 32'sd0 :
                               ($urandom_range(0, 1) ? ROT_ONE : -ROT_ONE)));
        for (int i = 9; i < 12; i++)
            send(pose_load(4'(i), $signed($urandom_range(0, ONE * 8)) - ONE * 4));
    endtask

    task automatic random_phase(int count);
        int unsigned k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 3)
                load_rigid_pose();
            else if (k < 7)
                send(pose_load(4'($urandom_range(0, 15)), $urandom));
            else if (k < 9)
                send(point(CMD_NONE, $urandom, $urandom, $urandom));
            else if (k < 55)
                send(point(CMD_FWD, coord_val(0), coord_val(0), coord_val(1)));
            else
                send(point(CMD_BACK, coord_val(0) + 32'd20971520,
                           coord_val(0) + 32'd15728640, coord_val(1)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: identity pose and default camera, then edge-case pose loads
        send(point(CMD_FWD, 0, 0, ONE));
        send(point(CMD_FWD, ONE, -ONE, 2 * ONE));
        send(point(CMD_FWD, ONE, ONE, 0));
        send(point(CMD_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 1));
        send(point(CMD_FWD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send(point(CMD_FWD, 5 * ONE, 3 * ONE, -ONE));
        send(point(CMD_BACK, 32'd20971520, 32'd15728640, ONE));
        send(point(CMD_BACK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send(point(CMD_BACK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send(point(CMD_BACK, 0, 0, 0));
        send(point(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(pose_load(4'd13, 32'hFFFF_FFFF));
        send(pose_load(4'd15, 32'h8000_0000));
        send(pose_load(4'd11, 32'h7FFF_FFFF));
        send(point(CMD_FWD, ONE, ONE, ONE));
        send(point(CMD_BACK, ONE, ONE, ONE));
        send(pose_load(4'd11, 0));
        send(pose_load(4'd0, 32'h8000_0000));
        send(point(CMD_FWD, ONE, ONE, ONE));
        send(point(CMD_BACK, 32'd30000000, 32'd10000000, 3 * ONE));
        send(pose_load(4'd0, ROT_ONE));
        random_phase(PHASE_ITEMS);

        // zero focal lengths and zero principal point
        set_camera(0, 0, 0, 0);
        send(point(CMD_BACK, ONE, ONE, ONE));
        send(point(CMD_FWD, ONE, ONE, ONE));
        random_phase(PHASE_ITEMS);

        // largest register values
        set_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);

        set_camera($urandom_range(1, 32'd100000000), $urandom_range(1, 32'd100000000),
                   $urandom_range(0, 32'd50000000), $urandom);
        random_phase(PHASE_ITEMS);

        drain();
        if (errors == 0)
            $display("pinhole_pose_projection_test: PASS");
        else
            $display("pinhole_pose_projection_test: FAIL");
        $finish;
    end

endmodule

[sim.f]
design/ppp_pkg.sv
design/pinhole_pose_projection.sv
verif/pinhole_pose_projection_checker.sv
verif/pinhole_pose_projection_test.sv
